// ===== sv/i2srd_pkg.sv =====
// Shared widths, constants and controller/datapath interface types for the I2S rate divider search.
package i2srd_pkg;

	// Field widths.
	localparam int CLK_W  = 28;
	localparam int BITS_W = 6;
	localparam int RATE_W = 20;
	localparam int N_W    = 7;
	localparam int XY_W   = 8;

	// Internal widths: the numerator is rate * bits * 4, the ratio dividend is that shifted by 16.
	localparam int NUM_W  = CLK_W;
	localparam int FRAC_W = 16;
	localparam int DIV_W  = NUM_W + FRAC_W;
	localparam int DCNT_W = $clog2(DIV_W + 1);
	localparam int XP_W   = NUM_W + N_W + XY_W;

	// Constants.
	localparam logic [CLK_W-1:0]  CLK_RESET = CLK_W'(204000000);
	localparam int                MAX_N_DEF = 64;
	localparam logic [XY_W-1:0]   Y_TOP     = 8'd255;
	localparam logic [XY_W-1:0]   X_MAX     = 8'hFF;
	localparam logic [FRAC_W-1:0] HALF_Q16  = 16'h8000;
	localparam logic [FRAC_W:0]   ONE_Q16   = 17'h10000;
	localparam logic [FRAC_W-1:0] FRAC_Q16  = 16'hFFFF;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic n_init;
		logic n_step;
		logic n_take;
		logic y_step;
		logic x_load;
		logic out_load;
		logic err;
	} i2srd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
		logic ratio_big;
		logic n_hit;
		logic cand_last;
		logic y_stop;
	} i2srd_sts_t;

endpackage

// ===== sv/i2srd_dp.sv =====
// Datapath of the I2S rate divider search: serial divider, N and Y search units, result register.
module i2srd_dp import i2srd_pkg::*; #(
	parameter int MAX_N = MAX_N_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CLK_W-1:0]  cfg_wdata,
	input  logic [BITS_W-1:0] word_bits,
	input  logic [RATE_W-1:0] sample_rate,
	input  i2srd_cmd_t        cmd,
	output i2srd_sts_t        sts,
	output logic              status,
	output logic [N_W-1:0]    div_n,
	output logic [XY_W-1:0]   x_div,
	output logic [XY_W-1:0]   y_div
);

	localparam int CW = $clog2(MAX_N + 1);

	logic [CLK_W-1:0]      clk_q;
	logic [NUM_W-1:0]      num_q;
	logic [DIV_W-1:0]      dq_q;
	logic [CLK_W-1:0]      dr_q;
	logic [DCNT_W-1:0]     dcnt_q;
	logic [FRAC_W-1:0]     ratio_q;
	logic [CW-1:0]         cand_q;
	logic [N_W-1:0]        n_q;
	logic [FRAC_W-1:0]     scaled_q;
	logic [NUM_W+N_W-1:0]  mnum_q;
	logic [XY_W-1:0]       y_q;
	logic [XY_W-1:0]       best_y_q;
	logic [FRAC_W-1:0]     best_err_q;
	logic                  status_q;
	logic [N_W-1:0]        div_n_q;
	logic [XY_W-1:0]       x_div_q;
	logic [XY_W-1:0]       y_div_q;

	logic [NUM_W-3:0]          wr_prod;
	logic [CLK_W:0]            dtrial;
	logic [CLK_W:0]            ddiff;
	logic                      dge;
	logic [FRAC_W+CW-1:0]      nprod;
	logic [FRAC_W+XY_W-1:0]    yprod;
	logic [FRAC_W-1:0]         yfrac;
	logic [FRAC_W-1:0]         yerr;
	logic [XP_W-1:0]           xprod;
	logic [XY_W-1:0]           xclamp;

	// Source clock register, reset to its nominal frequency.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_q <= CLK_RESET;
		end else if (cfg_we) begin
			clk_q <= cfg_wdata;
		end
	end

	// Word width times sample rate, at full width before the factor of four.
	assign wr_prod = (NUM_W-2)'(word_bits) * (NUM_W-2)'(sample_rate);

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	// A zero source clock makes every step subtract, so the ratio saturates and flags an error.
	assign dtrial = {dr_q, dq_q[DIV_W-1]};
	assign dge    = dtrial >= {1'b0, clk_q};
	assign ddiff  = dtrial - {1'b0, clk_q};

	// Candidate test for N and scaled ratio for the chosen N.
	assign nprod = ratio_q * cand_q;

	// Rounding error of Y * ratio * N to the nearest whole number.
	assign yprod = y_q * scaled_q;
	assign yfrac = yprod[FRAC_W-1:0];
	assign yerr  = (yfrac > HALF_Q16) ? FRAC_W'(ONE_Q16 - {1'b0, yfrac}) : yfrac;

	// Dividend of the X division.
	assign xprod = mnum_q * best_y_q;

	// X is clamped to the range 1 to 255.
	always_comb begin
		if (|dq_q[DIV_W-1:XY_W]) begin
			xclamp = X_MAX;
		end else if (dq_q[XY_W-1:0] == '0) begin
			xclamp = XY_W'(1);
		end else begin
			xclamp = dq_q[XY_W-1:0];
		end
	end

	// Working registers, driven by the controller's commands.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q  <= {wr_prod, 2'b00};
			dq_q   <= {wr_prod, 2'b00, {FRAC_W{1'b0}}};
			dr_q   <= '0;
			dcnt_q <= '0;
		end else if (cmd.x_load) begin
			dq_q   <= DIV_W'(xprod);
			dr_q   <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dq_q   <= {dq_q[DIV_W-2:0], dge};
			dr_q   <= dge ? ddiff[CLK_W-1:0] : dtrial[CLK_W-1:0];
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end

		if (cmd.n_init) begin
			ratio_q <= dq_q[FRAC_W-1:0];
			cand_q  <= CW'(MAX_N);
		end else if (cmd.n_step) begin
			cand_q <= cand_q - CW'(1);
		end

		if (cmd.n_take) begin
			n_q        <= N_W'(cand_q);
			scaled_q   <= nprod[FRAC_W-1:0];
			mnum_q     <= num_q * N_W'(cand_q);
			y_q        <= Y_TOP;
			best_y_q   <= Y_TOP;
			best_err_q <= FRAC_Q16;
		end else if (cmd.y_step) begin
			y_q <= y_q - XY_W'(1);
			if (yerr == '0) begin
				best_y_q <= y_q;
			end else if (yerr < best_err_q) begin
				best_err_q <= yerr;
				best_y_q   <= y_q;
			end
		end

		if (cmd.out_load) begin
			status_q <= cmd.err;
			div_n_q  <= cmd.err ? '0 : n_q;
			x_div_q  <= cmd.err ? '0 : xclamp;
			y_div_q  <= cmd.err ? '0 : best_y_q;
		end
	end

	// Status toward the controller.
	assign sts.div_done  = dcnt_q == DCNT_W'(DIV_W);
	assign sts.ratio_big = |dq_q[DIV_W-1:FRAC_W];
	assign sts.n_hit     = nprod[FRAC_W+CW-1:FRAC_W] == '0;
	assign sts.cand_last = cand_q == CW'(1);
	assign sts.y_stop    = (yerr == '0) || (y_q == XY_W'(1));

	assign status = status_q;
	assign div_n  = div_n_q;
	assign x_div  = x_div_q;
	assign y_div  = y_div_q;

`ifndef SYNTHESIS
	// A successful result always carries nonzero dividers within range.
	a_success_fields: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && !cmd.err |=> div_n != '0 && x_div != '0 && y_div != '0
		&& div_n <= N_W'(MAX_N))
		else $error("successful result with out-of-range divider");
`endif

endmodule

// ===== sv/i2srd_ctrl.sv =====
// Controller state machine of the I2S rate divider search.
module i2srd_ctrl import i2srd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  i2srd_sts_t sts,
	output i2srd_cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DIVA  = 7'b0000010,
		S_NSRCH = 7'b0000100,
		S_YSRCH = 7'b0001000,
		S_XMUL  = 7'b0010000,
		S_DIVB  = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   err_q;
	logic   err_d;
	logic   out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		err_d   = err_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					err_d    = 1'b0;
					state_d  = S_DIVA;
				end
			end
			S_DIVA: begin
				if (!sts.div_done) begin
					cmd.div_step = 1'b1;
				end else if (sts.ratio_big) begin
					err_d   = 1'b1;
					state_d = S_FIN;
				end else begin
					cmd.n_init = 1'b1;
					state_d    = S_NSRCH;
				end
			end
			S_NSRCH: begin
				if (sts.n_hit) begin
					cmd.n_take = 1'b1;
					state_d    = S_YSRCH;
				end else begin
					cmd.n_step = 1'b1;
				end
			end
			S_YSRCH: begin
				cmd.y_step = 1'b1;
				if (sts.y_stop) begin
					state_d = S_XMUL;
				end
			end
			S_XMUL: begin
				cmd.x_load = 1'b1;
				state_d    = S_DIVB;
			end
			S_DIVB: begin
				if (!sts.div_done) begin
					cmd.div_step = 1'b1;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		cmd.err = err_q;
	end

	// State, error flag and result-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	// The N search always finds a candidate before running out.
	a_n_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_NSRCH && sts.cand_last |-> sts.n_hit)
		else $error("N search ran past the last candidate");

	// An accepted transaction starts the ratio division with a clean error flag.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DIVA && !err_q)
		else $error("accepted transaction did not start the division");

	// Loading the result register always presents a result.
	a_present: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not presented");
`endif

endmodule

// ===== sv/i2s_rate_divider_search_top.sv =====
// From acceptance to result valid: the first 44-step serial division, the N search down from
// MAX_N, the Y search over 255 candidates, the X product and the second 44-step division;
// an error result (ratio too large) skips all steps after the first division.
// Throughput: one transaction at a time; the next is taken once the result is in the output
// register, even while that result waits. Reset returns the source clock register to
// 204000000, idles the controller and drops any pending result.
module i2s_rate_divider_search_top import i2srd_pkg::*; #(
	parameter int MAX_N = MAX_N_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CLK_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BITS_W-1:0] word_bits,
	input  logic [RATE_W-1:0] sample_rate,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              status,
	output logic [N_W-1:0]    div_n,
	output logic [XY_W-1:0]   x_div,
	output logic [XY_W-1:0]   y_div
);

	i2srd_cmd_t cmd;
	i2srd_sts_t sts;

	// Sequencing.
	i2srd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Arithmetic and result register.
	i2srd_dp #(
		.MAX_N (MAX_N)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.word_bits   (word_bits),
		.sample_rate (sample_rate),
		.cmd         (cmd),
		.sts         (sts),
		.status      (status),
		.div_n       (div_n),
		.x_div       (x_div),
		.y_div       (y_div)
	);

endmodule
